// ----- hw/rtl/modexp_pkg.sv -----
// Shared widths, constants and sequencer states for the modular exponentiation core.
package modexp_pkg;

    localparam int MOD_W  = 31;
    localparam int OPND_W = 32;
    localparam int EXP_W  = 32;
    localparam int CNT_W  = $clog2(OPND_W);

    localparam logic [CNT_W-1:0] STEP_LAST   = CNT_W'(OPND_W - 1);
    localparam logic [MOD_W-1:0] MOD_RESET   = MOD_W'(23);
    localparam logic [MOD_W-1:0] MOD_ONE     = MOD_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } modexp_state_t;

endpackage

// ----- hw/rtl/modular_exponentiation_core.sv -----
// Modular exponentiation core: right-to-left square-and-multiply over a shared mod-multiply unit.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_base_value[31:0], s_exponent[31:0]
//  m_        out        m_valid / m_ready    m_power_result[30:0]
//  cfg_      in         cfg_we               cfg_wdata[30:0] (modulus, 0 acts as 1)
//
//  One shared interleaved mod-multiply unit retires one multiplier bit per cycle.
//  A transaction runs a base reduction, then multiplies and squares, stopping once the
//  remaining exponent bits are zero (at most 2 * min(EXP_BITS, 32) - 1 multiplies), then hands off.
//  s_ready is high only between transactions; a finished result waits in the output
//  register, so the next transaction is taken while m_ready is low.
//  Reset is synchronous on aresetn, and sets the modulus to 23.
module modular_exponentiation_core #(
    parameter int EXP_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [modexp_pkg::MOD_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [modexp_pkg::OPND_W-1:0] s_base_value,
    input  logic [modexp_pkg::EXP_W-1:0] s_exponent,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [modexp_pkg::MOD_W-1:0] m_power_result
);
    import modexp_pkg::*;

    localparam int PROC_BITS = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;

    modexp_state_t state_reg, state_next;

    logic [MOD_W-1:0]     modulus_reg;
    logic [MOD_W-1:0]     mod_eff;
    logic [MOD_W-1:0]     acc_reg;
    logic [OPND_W-1:0]    mplier_reg;
    logic [MOD_W-1:0]     mcand_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [PROC_BITS-1:0] exp_reg;
    logic [MOD_W-1:0]     base_reg;
    logic [MOD_W-1:0]     res_reg;
    logic                 m_valid_reg;
    logic [MOD_W-1:0]     m_power_result_reg;

    logic [MOD_W+1:0]     dbl;
    logic [MOD_W+2:0]     diff1;
    logic [MOD_W+2:0]     diff2;
    logic [MOD_W-1:0]     step_val;
    logic                 unit_last;
    logic                 unit_run;
    logic                 unit_load;
    logic [OPND_W-1:0]    ld_mplier;
    logic [MOD_W-1:0]     ld_mcand;
    logic                 disp;
    logic [PROC_BITS-1:0] disp_exp;
    logic                 out_load;
    logic                 ready_c;
    logic                 accept;

    assign mod_eff = (modulus_reg == '0) ? MOD_ONE : modulus_reg;

    // Interleaved step: acc = (2*acc + bit*mcand) mod m, with acc < m kept throughout.
    assign dbl   = {1'b0, acc_reg, 1'b0}
                 + {2'b00, (mplier_reg[OPND_W-1] ? mcand_reg : MOD_W'(0))};
    assign diff1 = {1'b0, dbl} - {3'b000, mod_eff};
    assign diff2 = {1'b0, dbl} - {2'b00, mod_eff, 1'b0};

    always_comb begin
        if (!diff2[MOD_W+2]) begin
            step_val = diff2[MOD_W-1:0];
        end else if (!diff1[MOD_W+2]) begin
            step_val = diff1[MOD_W-1:0];
        end else begin
            step_val = dbl[MOD_W-1:0];
        end
    end

    assign unit_last = (cnt_reg == STEP_LAST);
    assign unit_run  = (state_reg == ST_REDUCE) || (state_reg == ST_MUL) ||
                       (state_reg == ST_SQR);
    assign accept    = s_valid && ready_c;

    always_comb begin
        state_next = state_reg;
        unit_load  = 1'b0;
        ld_mplier  = '0;
        ld_mcand   = '0;
        disp       = 1'b0;
        disp_exp   = exp_reg;
        out_load   = 1'b0;
        ready_c    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ready_c = 1'b1;
                if (s_valid) begin
                    state_next = ST_REDUCE;
                    unit_load  = 1'b1;
                    ld_mplier  = s_base_value;
                    ld_mcand   = MOD_ONE;
                end
            end
            ST_REDUCE: begin
                if (unit_last) begin
                    disp     = 1'b1;
                    disp_exp = exp_reg;
                end
            end
            ST_MUL: begin
                if (unit_last) begin
                    if ((exp_reg >> 1) == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SQR;
                        unit_load  = 1'b1;
                        ld_mplier  = {1'b0, base_reg};
                        ld_mcand   = base_reg;
                    end
                end
            end
            ST_SQR: begin
                if (unit_last) begin
                    disp     = 1'b1;
                    disp_exp = exp_reg >> 1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (disp) begin
            if (disp_exp == '0) begin
                state_next = ST_FINISH;
            end else if (disp_exp[0]) begin
                state_next = ST_MUL;
                unit_load  = 1'b1;
                ld_mplier  = {1'b0, res_reg};
                ld_mcand   = step_val;
            end else begin
                state_next = ST_SQR;
                unit_load  = 1'b1;
                ld_mplier  = {1'b0, step_val};
                ld_mcand   = step_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            modulus_reg <= MOD_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                modulus_reg <= cfg_wdata;
            end
            if (unit_load) begin
                cnt_reg <= '0;
            end else if (unit_run) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (unit_load) begin
            acc_reg    <= '0;
            mplier_reg <= ld_mplier;
            mcand_reg  <= ld_mcand;
        end else if (unit_run) begin
            acc_reg    <= step_val;
            mplier_reg <= {mplier_reg[OPND_W-2:0], 1'b0};
        end
        if (accept) begin
            exp_reg <= s_exponent[PROC_BITS-1:0];
            res_reg <= MOD_ONE;
        end else begin
            if ((state_reg == ST_SQR) && unit_last) begin
                exp_reg <= exp_reg >> 1;
            end
            if ((state_reg == ST_MUL) && unit_last) begin
                res_reg <= step_val;
            end
        end
        if (((state_reg == ST_REDUCE) || (state_reg == ST_SQR)) && unit_last) begin
            base_reg <= step_val;
        end
        if (out_load) begin
            m_power_result_reg <= res_reg;
        end
    end

    assign s_ready        = ready_c;
    assign m_valid        = m_valid_reg;
    assign m_power_result = m_power_result_reg;

`ifndef SYNTHESIS
    a_accept_starts_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_REDUCE) && (cnt_reg == '0) &&
                                 (res_reg == MOD_ONE))
        else $error("accepted transaction did not start base reduction");

    a_finish_holds_blocked_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FINISH) && m_valid_reg && !m_ready) |=>
            m_valid_reg && $stable(m_power_result_reg) && (state_reg == ST_FINISH))
        else $error("pending result overwritten");

    a_finish_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FINISH) && (!m_valid_reg || m_ready)) |=>
            m_valid_reg && (m_power_result_reg == $past(res_reg)) && (state_reg == ST_IDLE))
        else $error("finished result not handed to output register");

    a_counter_idle_outside_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> ((state_reg == ST_REDUCE) || (state_reg == ST_MUL) ||
                             (state_reg == ST_SQR)))
        else $error("step counter running outside a multiply");
`endif

endmodule
